>>> hw/rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants
// Transaction payloads, status codes and sequencer states of the range
// allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int FIELD_W = 24;
  localparam logic [FIELD_W-1:0] TOTAL_RESET_VAL = 24'd65536;

  typedef enum logic [2:0] {
    STATUS_UNCHANGED = 3'd0,
    STATUS_ALLOCATED = 3'd1,
    STATUS_RELEASED  = 3'd2,
    STATUS_NO_SPACE  = 3'd3,
    STATUS_LIST_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] old_offset;
    logic [FIELD_W-1:0] old_length;
    logic [FIELD_W-1:0] new_length;
  } request_t;

  typedef struct packed {
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_size;
    status_t            status;
  } result_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_INIT,
    SEQ_GB_RD,
    SEQ_GB_CHK,
    SEQ_GB_UPD,
    SEQ_UP_RD,
    SEQ_UP_WR,
    SEQ_INS,
    SEQ_DN_RD,
    SEQ_DN_WR,
    SEQ_DECIDE,
    SEQ_FF_RD,
    SEQ_FF_CHK
  } seq_state_t;

endpackage

>>> hw/rtl/ffra_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_mem: free list storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffra_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl: free list sequencer
// Scans, merges, shifts and carves free ranges through the list memory.
// ----------------------------------------------------------------------------
module ffra_ctrl #(
  parameter int FREE_SLOTS = 64,
  parameter int ADDR_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ffra_pkg::request_t    request,
  input  logic                  cfg_we,
  input  logic [ADDR_BITS-1:0]  total,
  output logic                  busy,
  output logic                  fin,
  output ffra_pkg::result_t     fin_result
);

  localparam int A  = ADDR_BITS;
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int F  = ffra_pkg::FIELD_W;

  ffra_pkg::seq_state_t state, state_next;

  logic [CW-1:0]    cnt, idx, j;
  logic [2*A-1:0]   prev_ent, cur_ent;
  logic             have_prev, alloc;
  logic [A-1:0]     s_reg, l_reg, nl_reg, alloc_start;

  logic             we, re;
  logic [IW-1:0]    waddr, raddr;
  logic [2*A-1:0]   wdata, rdata;

  logic [A+F-1:0]   off_w, ol_w, nl_w;
  logic [A-1:0]     in_off, in_ol, in_nl;
  logic [A-1:0]     rd_start, rd_len, prev_start, prev_len, cur_start, cur_len;
  logic [A:0]       prev_end, blk_end;
  logic             cur_valid, join_prev, join_next, full, fits;
  logic [A+1:0]     sum_both, sum_prev, sum_next;
  logic [A-1:0]     sat_both, sat_prev, sat_next;
  logic [CW-1:0]    idx_m1, j_p1, j_m1;

  // Mask inputs to the address width.
  assign off_w  = {{A{1'b0}}, request.old_offset};
  assign ol_w   = {{A{1'b0}}, request.old_length};
  assign nl_w   = {{A{1'b0}}, request.new_length};
  assign in_off = off_w[A-1:0];
  assign in_ol  = ol_w[A-1:0];
  assign in_nl  = nl_w[A-1:0];

  assign rd_start   = rdata[2*A-1:A];
  assign rd_len     = rdata[A-1:0];
  assign prev_start = prev_ent[2*A-1:A];
  assign prev_len   = prev_ent[A-1:0];
  assign cur_start  = cur_ent[2*A-1:A];
  assign cur_len    = cur_ent[A-1:0];

  assign prev_end  = {1'b0, prev_start} + {1'b0, prev_len};
  assign blk_end   = {1'b0, s_reg} + {1'b0, l_reg};
  assign cur_valid = idx < cnt;
  assign join_prev = have_prev && (prev_end == {1'b0, s_reg});
  assign join_next = cur_valid && (blk_end == {1'b0, cur_start});
  assign full      = cnt >= CW'(FREE_SLOTS);
  assign fits      = rd_len >= nl_reg;

  // Merged lengths saturate at the top of the address space.
  assign sum_both = {2'b00, prev_len} + {2'b00, l_reg} + {2'b00, cur_len};
  assign sum_prev = {2'b00, prev_len} + {2'b00, l_reg};
  assign sum_next = {2'b00, l_reg} + {2'b00, cur_len};
  assign sat_both = (sum_both[A+1:A] != 2'b00) ? {A{1'b1}} : sum_both[A-1:0];
  assign sat_prev = (sum_prev[A+1:A] != 2'b00) ? {A{1'b1}} : sum_prev[A-1:0];
  assign sat_next = (sum_next[A+1:A] != 2'b00) ? {A{1'b1}} : sum_next[A-1:0];

  assign idx_m1 = idx - 1'b1;
  assign j_p1   = j + 1'b1;
  assign j_m1   = j - 1'b1;

  function automatic logic [F-1:0] to_field(input logic [A-1:0] v);
    logic [A+F-1:0] w;
    w = {{F{1'b0}}, v};
    return w[F-1:0];
  endfunction

  ffra_mem #(.DEPTH(FREE_SLOTS), .WIDTH(2 * A)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ffra_pkg::SEQ_IDLE: begin
        if (cfg_we) begin
          state_next = ffra_pkg::SEQ_INIT;
        end else if (start) begin
          if (in_ol == in_nl) state_next = ffra_pkg::SEQ_IDLE;
          else if (in_ol != '0) state_next = ffra_pkg::SEQ_GB_RD;
          else state_next = ffra_pkg::SEQ_DECIDE;
        end
      end
      ffra_pkg::SEQ_INIT:   state_next = ffra_pkg::SEQ_IDLE;
      ffra_pkg::SEQ_GB_RD: begin
        state_next = cur_valid ? ffra_pkg::SEQ_GB_CHK : ffra_pkg::SEQ_GB_UPD;
      end
      ffra_pkg::SEQ_GB_CHK: begin
        state_next = (rd_start < s_reg) ? ffra_pkg::SEQ_GB_RD : ffra_pkg::SEQ_GB_UPD;
      end
      ffra_pkg::SEQ_GB_UPD: begin
        if (join_prev && join_next) state_next = ffra_pkg::SEQ_DN_RD;
        else if (join_prev || join_next) state_next = ffra_pkg::SEQ_DECIDE;
        else if (full) state_next = ffra_pkg::SEQ_IDLE;
        else state_next = ffra_pkg::SEQ_UP_RD;
      end
      ffra_pkg::SEQ_UP_RD: begin
        state_next = (j > idx) ? ffra_pkg::SEQ_UP_WR : ffra_pkg::SEQ_INS;
      end
      ffra_pkg::SEQ_UP_WR:  state_next = ffra_pkg::SEQ_UP_RD;
      ffra_pkg::SEQ_INS:    state_next = ffra_pkg::SEQ_DECIDE;
      ffra_pkg::SEQ_DN_RD: begin
        if (j_p1 < cnt) state_next = ffra_pkg::SEQ_DN_WR;
        else if (alloc) state_next = ffra_pkg::SEQ_IDLE;
        else state_next = ffra_pkg::SEQ_DECIDE;
      end
      ffra_pkg::SEQ_DN_WR:  state_next = ffra_pkg::SEQ_DN_RD;
      ffra_pkg::SEQ_DECIDE: begin
        state_next = (nl_reg == '0) ? ffra_pkg::SEQ_IDLE : ffra_pkg::SEQ_FF_RD;
      end
      ffra_pkg::SEQ_FF_RD: begin
        state_next = cur_valid ? ffra_pkg::SEQ_FF_CHK : ffra_pkg::SEQ_IDLE;
      end
      ffra_pkg::SEQ_FF_CHK: begin
        if (!fits) state_next = ffra_pkg::SEQ_FF_RD;
        else if (rd_len == nl_reg) state_next = ffra_pkg::SEQ_DN_RD;
        else state_next = ffra_pkg::SEQ_IDLE;
      end
      default: state_next = ffra_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;
    fin        = 1'b0;
    fin_result = '0;
    case (state)
      ffra_pkg::SEQ_IDLE: begin
        if (start && !cfg_we && (in_ol == in_nl)) begin
          fin                    = 1'b1;
          fin_result.range_start = to_field(in_off);
          fin_result.range_size  = to_field(in_ol);
          fin_result.status      = ffra_pkg::STATUS_UNCHANGED;
        end
      end
      ffra_pkg::SEQ_INIT: begin
        we    = total != '0;
        wdata = {{A{1'b0}}, total};
      end
      ffra_pkg::SEQ_GB_RD: begin
        re    = cur_valid;
        raddr = idx[IW-1:0];
      end
      ffra_pkg::SEQ_GB_UPD: begin
        if (join_prev) begin
          we    = 1'b1;
          waddr = idx_m1[IW-1:0];
          wdata = {prev_start, join_next ? sat_both : sat_prev};
        end else if (join_next) begin
          we    = 1'b1;
          waddr = idx[IW-1:0];
          wdata = {s_reg, sat_next};
        end else if (full) begin
          fin                    = 1'b1;
          fin_result.range_start = to_field(s_reg);
          fin_result.range_size  = to_field(l_reg);
          fin_result.status      = ffra_pkg::STATUS_LIST_FULL;
        end
      end
      ffra_pkg::SEQ_UP_RD: begin
        re    = j > idx;
        raddr = j_m1[IW-1:0];
      end
      ffra_pkg::SEQ_UP_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rdata;
      end
      ffra_pkg::SEQ_INS: begin
        we    = 1'b1;
        waddr = idx[IW-1:0];
        wdata = {s_reg, l_reg};
      end
      ffra_pkg::SEQ_DN_RD: begin
        re    = j_p1 < cnt;
        raddr = j_p1[IW-1:0];
        if (!(j_p1 < cnt) && alloc) begin
          fin                    = 1'b1;
          fin_result.range_start = to_field(alloc_start);
          fin_result.range_size  = to_field(nl_reg);
          fin_result.status      = ffra_pkg::STATUS_ALLOCATED;
        end
      end
      ffra_pkg::SEQ_DN_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rdata;
      end
      ffra_pkg::SEQ_DECIDE: begin
        if (nl_reg == '0) begin
          fin               = 1'b1;
          fin_result.status = ffra_pkg::STATUS_RELEASED;
        end
      end
      ffra_pkg::SEQ_FF_RD: begin
        re    = cur_valid;
        raddr = idx[IW-1:0];
        if (!cur_valid) begin
          fin               = 1'b1;
          fin_result.status = ffra_pkg::STATUS_NO_SPACE;
        end
      end
      ffra_pkg::SEQ_FF_CHK: begin
        if (fits && (rd_len != nl_reg)) begin
          we                     = 1'b1;
          waddr                  = idx[IW-1:0];
          wdata                  = {rd_start + nl_reg, rd_len - nl_reg};
          fin                    = 1'b1;
          fin_result.range_start = to_field(rd_start);
          fin_result.range_size  = to_field(nl_reg);
          fin_result.status      = ffra_pkg::STATUS_ALLOCATED;
        end
      end
      default: ;
    endcase
  end

  assign busy = state != ffra_pkg::SEQ_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::SEQ_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ffra_pkg::SEQ_IDLE: begin
          if (start && !cfg_we) begin
            s_reg     <= in_off;
            l_reg     <= in_ol;
            nl_reg    <= in_nl;
            idx       <= '0;
            have_prev <= 1'b0;
            alloc     <= 1'b0;
          end
        end
        ffra_pkg::SEQ_INIT:   cnt <= (total != '0) ? CW'(1) : '0;
        ffra_pkg::SEQ_GB_CHK: begin
          if (rd_start < s_reg) begin
            prev_ent  <= rdata;
            have_prev <= 1'b1;
            idx       <= idx + 1'b1;
          end else begin
            cur_ent <= rdata;
          end
        end
        ffra_pkg::SEQ_GB_UPD: begin
          if (join_prev && join_next) j <= idx;
          else if (!join_prev && !join_next) j <= cnt;
        end
        ffra_pkg::SEQ_UP_WR:  j <= j_m1;
        ffra_pkg::SEQ_INS:    cnt <= cnt + 1'b1;
        ffra_pkg::SEQ_DN_RD: begin
          if (!(j_p1 < cnt)) cnt <= cnt - 1'b1;
        end
        ffra_pkg::SEQ_DN_WR:  j <= j_p1;
        ffra_pkg::SEQ_DECIDE: begin
          idx   <= '0;
          alloc <= 1'b1;
        end
        ffra_pkg::SEQ_FF_CHK: begin
          if (!fits) begin
            idx <= idx + 1'b1;
          end else if (rd_len == nl_reg) begin
            j           <= idx;
            alloc_start <= rd_start;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(FREE_SLOTS))
    else $error("free list count beyond capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (fin && fin_result.status == ffra_pkg::STATUS_LIST_FULL) |-> full)
    else $error("list full reported with free slots left");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    we |-> ({1'b0, waddr} <= {1'b0, cnt}))
    else $error("write beyond end of free list");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ffra_pkg::SEQ_IDLE) |-> !we)
    else $error("memory write while idle");

endmodule

>>> hw/rtl/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit allocator with coalescing free list
// Resizes a caller's range: frees the old range, merges it with its free
// neighbors, then carves the first free range large enough.
// ----------------------------------------------------------------------------
//  channel   handshake               payload          direction
//  request   start & !busy           request_t        in
//  result    done (one cycle)        result_t         out
//  config    cfg_valid & cfg_ready   cfg_data[23:0]   in
//
//  An unchanged length raises done in the cycle after start is taken;
//  otherwise a request walks the free list in the release scan, the shift
//  for insert or removal and the first-fit scan, through the single read
//  port of the list memory.
//  Reset and each config write rebuild the list in the SEQ_INIT state.
//  The receiver cannot stall: done pulses for exactly one cycle.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
  parameter int FREE_SLOTS = 64,
  parameter int ADDR_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ffra_pkg::request_t request,
  output logic               done,
  output ffra_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);

  localparam int A = ADDR_BITS;

  logic [A-1:0]       total;
  logic [A+23:0]      cfg_wide;
  logic               cfg_we;
  logic               fin;
  ffra_pkg::result_t  fin_result;

  // Take config only while idle and no request is offered; the write
  // restarts the free list.
  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_wide  = {{A{1'b0}}, cfg_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= A'(ffra_pkg::TOTAL_RESET_VAL);
    end else if (cfg_we) begin
      total <= cfg_wide[A-1:0];
    end
  end

  ffra_ctrl #(.FREE_SLOTS(FREE_SLOTS), .ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .request    (request),
    .cfg_we     (cfg_we),
    .total      (total),
    .busy       (busy),
    .fin        (fin),
    .fin_result (fin_result)
  );

  // Register the result transaction; hold payload, pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result <= fin_result;
    end
  end

endmodule
